FILE: design/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants for the priority message queue: transaction
// payloads, stored entry layout, status and command codes.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int unsigned ReqPrioW  = 16;
  localparam int unsigned ReqLenW   = 16;
  localparam int unsigned DescW     = 32;
  localparam int unsigned PrioW     = 15;
  localparam int unsigned LenW      = 14;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned BytesW    = 18;
  localparam int unsigned MaxMsgW   = 5;
  localparam int unsigned MaxSizeW  = 14;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // largest accepted message length and number of priority levels
  localparam int unsigned MaxLength      = 8192;
  localparam int unsigned PriorityLevels = 32768;

  localparam logic [MaxMsgW-1:0]  MaxMsgRst  = 5'd10;
  localparam logic [MaxSizeW-1:0] MaxSizeRst = 14'd8192;

  typedef enum logic [0:0] {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_PRIO  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BUF_SMALL = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_MESSAGES     = 2'd0,
    CFG_MAX_MESSAGE_SIZE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                command;
    logic [ReqPrioW-1:0] priority_req;
    logic [ReqLenW-1:0]  length;
    logic [DescW-1:0]    payload;
  } pmq_in_t;

  typedef struct packed {
    status_e              status;
    logic [PrioW-1:0]     out_priority;
    logic [LenW-1:0]      out_length;
    logic [DescW-1:0]     out_payload;
    logic [CountOutW-1:0] message_count;
    logic [BytesW-1:0]    queued_bytes;
  } pmq_out_t;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [LenW-1:0]  len;
    logic [DescW-1:0] desc;
  } pmq_entry_t;

  // per-cycle command to every cell of the row
  typedef struct packed {
    logic insert;
    logic remove;
  } pmq_cell_ctl_t;

endpackage

FILE: design/pmq_cell.sv
// ----------------------------------------------------------------------------
// pmq_cell
// One slot of the sorted entry row. Holds, takes the new entry, takes its
// left neighbor on insert, or takes its right neighbor on remove.
// ----------------------------------------------------------------------------
module pmq_cell
  import pmq_pkg::*;
(
  input  logic          clk_i,
  input  pmq_cell_ctl_t ctl_i,
  input  pmq_entry_t    new_i,
  input  pmq_entry_t    left_i,
  input  pmq_entry_t    right_i,
  input  logic          left_ge_i,
  input  logic          occupied_i,
  output logic          ge_o,
  output pmq_entry_t    entry_o
);

  pmq_entry_t entry_q, entry_d;

  // equal priority stays ahead, so arrival order holds within a level
  assign ge_o    = occupied_i && (entry_q.prio >= new_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (!ge_o) begin
        entry_d = left_ge_i ? new_i : left_i;
      end
    end else if (ctl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: design/priority_message_queue.sv
// Result: registered, presented in the cycle after its command transaction.
// Throughput: one transaction per cycle if no result stalls; the priority
// compare runs in every cell in parallel; insert position is combinational.
// Reset: asynchronous, active low; queue empties, byte total clears, limits
// return to 10 messages and 8192 bytes. Entry contents are not cleared.
// ----------------------------------------------------------------------------
// priority_message_queue
// Bounded message queue served highest priority first, arrival order kept
// within one priority, held as a sorted row of cells.
// ----------------------------------------------------------------------------
module priority_message_queue
  import pmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmq_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmq_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > MaxMsgW) ? CntW : MaxMsgW;

  logic [MaxMsgW-1:0]  max_msgs_q;
  logic [MaxSizeW-1:0] max_size_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [BytesW-1:0]   bytes_q, bytes_d;
  logic                out_valid_q;
  pmq_out_t            out_q, out_d;

  pmq_entry_t    entries [QUEUE_DEPTH];
  logic          ge      [QUEUE_DEPTH];
  pmq_entry_t    new_entry;
  pmq_cell_ctl_t cell_ctl;

  logic     accept;
  logic     bad_prio, too_large, full, buf_small, empty;
  status_e  status;
  logic [CmpW-1:0] count_ext, count_d_ext;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign new_entry.prio = in_data_i.priority_req[PrioW-1:0];
  assign new_entry.len  = in_data_i.length[LenW-1:0];
  assign new_entry.desc = in_data_i.payload;

  assign count_ext = CmpW'(count_q);

  assign bad_prio  = {1'b0, in_data_i.priority_req} >= 17'(PriorityLevels);
  assign too_large = (in_data_i.length > ReqLenW'(max_size_q)) ||
                     ({1'b0, in_data_i.length} > 17'(MaxLength));
  assign full      = (count_ext >= CmpW'(max_msgs_q)) ||
                     (count_ext >= CmpW'(QUEUE_DEPTH));
  assign buf_small = in_data_i.length < ReqLenW'(max_size_q);
  assign empty     = (count_q == '0);

  always_comb begin
    if (in_data_i.command == CMD_SEND) begin
      if (bad_prio) begin
        status = ST_BAD_PRIO;
      end else if (too_large) begin
        status = ST_TOO_LARGE;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
      end
    end else begin
      if (buf_small) begin
        status = ST_BUF_SMALL;
      end else if (empty) begin
        status = ST_EMPTY;
      end else begin
        status = ST_OK;
      end
    end
  end

  assign cell_ctl.insert = accept && (in_data_i.command == CMD_SEND) && (status == ST_OK);
  assign cell_ctl.remove = accept && (in_data_i.command == CMD_RECV) && (status == ST_OK);

  always_comb begin
    count_d = count_q;
    bytes_d = bytes_q;
    if (cell_ctl.insert) begin
      count_d = count_q + CntW'(1);
      bytes_d = bytes_q + BytesW'(new_entry.len);
    end else if (cell_ctl.remove) begin
      count_d = count_q - CntW'(1);
      bytes_d = bytes_q - BytesW'(entries[0].len);
    end
  end

  assign count_d_ext = CmpW'(count_d);

  always_comb begin
    out_d               = '0;
    out_d.status        = status;
    out_d.message_count = count_d_ext[CountOutW-1:0];
    out_d.queued_bytes  = bytes_d;
    if (cell_ctl.remove) begin
      out_d.out_priority = entries[0].prio;
      out_d.out_length   = entries[0].len;
      out_d.out_payload  = entries[0].desc;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pmq_entry_t left_entry, right_entry;
    logic       left_ge, occupied;

    if (i == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_ge    = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    assign occupied = count_q > CntW'(i);

    pmq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl),
      .new_i      (new_entry),
      .left_i     (left_entry),
      .right_i    (right_entry),
      .left_ge_i  (left_ge),
      .occupied_i (occupied),
      .ge_o       (ge[i]),
      .entry_o    (entries[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
      max_msgs_q  <= MaxMsgRst;
      max_size_q  <= MaxSizeRst;
    end else begin
      count_q <= count_d;
      bytes_q <= bytes_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAX_MESSAGES:     max_msgs_q <= cfg_data_i[MaxMsgW-1:0];
          CFG_MAX_MESSAGE_SIZE: max_size_q <= cfg_data_i[MaxSizeW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: design/pmq_checker.sv
// ----------------------------------------------------------------------------
// pmq_port_checks
// Port-level checks on the priority message queue, bound to the top level.
// ----------------------------------------------------------------------------
module pmq_port_checks
  import pmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pmq_out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // every command transaction yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after command transaction");

  // refused commands carry no message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.out_priority == '0 && out_data_o.out_length == '0 &&
      out_data_o.out_payload == '0)
    else $error("refused command returned message data");

  // an empty report never comes with queued messages or bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.message_count == '0 && out_data_o.queued_bytes == '0)
    else $error("empty status with nonzero occupancy");

  // reported count never goes past the row length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.message_count <= QUEUE_DEPTH)
    else $error("message count beyond queue depth");

endmodule

bind priority_message_queue pmq_port_checks #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pmq_checker (.*);

FILE: dv/pmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_checker
// Watches the command, result and register channels of the priority message
// queue, keeps its own copy of the queue contents and limits, and compares
// every result transaction field by field against the predicted one.
// ----------------------------------------------------------------------------
module pmq_checker
  import pmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  pmq_in_t             in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  pmq_out_t            out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  pmq_entry_t             held_msgs_q[$];
  pmq_out_t               due_results_q[$];
  int unsigned            held_bytes;
  logic [MaxMsgW-1:0]     limit_msgs;
  logic [MaxSizeW-1:0]    limit_size;
  int                     fails = 0;
  int                     checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = due_results_q.size();
  assign checked_o    = checked;

  // applies one command to the shadow queue and returns the result it causes
  function automatic pmq_out_t predict_command(input pmq_in_t cmd);
    pmq_out_t   res;
    pmq_entry_t entry;
    int         pos;
    res = '0;
    res.status = ST_OK;
    if (cmd.command == CMD_SEND) begin
      if (cmd.priority_req >= PriorityLevels) begin
        res.status = ST_BAD_PRIO;
      end else if (cmd.length > limit_size || cmd.length > MaxLength) begin
        res.status = ST_TOO_LARGE;
      end else if (held_msgs_q.size() >= limit_msgs || held_msgs_q.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        entry.prio = cmd.priority_req[PrioW-1:0];
        entry.len  = cmd.length[LenW-1:0];
        entry.desc = cmd.payload;
        // goes behind every message of equal or higher priority
        pos = 0;
        while (pos < held_msgs_q.size() && held_msgs_q[pos].prio >= entry.prio) pos++;
        held_msgs_q.insert(pos, entry);
        held_bytes += cmd.length;
      end
    end else begin
      if (cmd.length < limit_size) begin
        res.status = ST_BUF_SMALL;
      end else if (held_msgs_q.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        entry = held_msgs_q.pop_front();
        res.out_priority = entry.prio;
        res.out_length   = entry.len;
        res.out_payload  = entry.desc;
        held_bytes -= entry.len;
      end
    end
    res.message_count = CountOutW'(held_msgs_q.size());
    res.queued_bytes  = BytesW'(held_bytes);
    return res;
  endfunction

  task automatic flag_field(input string field, input longint unsigned want,
                            input longint unsigned got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pmq_out_t want;
    if (!rst_ni) begin
      held_msgs_q.delete();
      due_results_q.delete();
      held_bytes = 0;
      limit_msgs = MaxMsgRst;
      limit_size = MaxSizeRst;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_MESSAGES:     limit_msgs = cfg_data_i[MaxMsgW-1:0];
          CFG_MAX_MESSAGE_SIZE: limit_size = cfg_data_i[MaxSizeW-1:0];
          default: ;
        endcase
      end
      // a result never belongs to the command taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (due_results_q.size() == 0) begin
          fails++;
          $error("result transaction with no command waiting for it");
        end else begin
          want = due_results_q.pop_front();
          checked++;
          flag_field("status", want.status, out_data_i.status);
          flag_field("out_priority", want.out_priority, out_data_i.out_priority);
          flag_field("out_length", want.out_length, out_data_i.out_length);
          flag_field("out_payload", want.out_payload, out_data_i.out_payload);
          flag_field("message_count", want.message_count, out_data_i.message_count);
          flag_field("queued_bytes", want.queued_bytes, out_data_i.queued_bytes);
        end
      end
      if (in_valid_i && in_ready_i) due_results_q.push_back(predict_command(in_data_i));
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the priority message queue with directed corner commands and then
// mostly well-formed random send and receive traffic under several limit
// settings and pacing modes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import pmq_pkg::*;

  localparam int unsigned QueueDepth = 16;
  // register indexes past the two real ones, ignored by the block
  localparam logic [CfgIdxW-1:0] CfgIdxSpare0 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare1 = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  pmq_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  pmq_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int fail_count;
  int pending_count;
  int result_count;

  int in_idle_pct  = 38;
  int out_idle_pct = 75;
  int cur_size     = MaxSizeRst;
  int sent_count   = 0;
  int reg_writes   = 0;

  // limit settings per random stretch, extremes and masked values included
  logic [CfgDataW-1:0] msg_limit_tab [9] = '{16'd16, 16'd1, 16'hFFFF, 16'd0, 16'd4,
                                             16'hFFF0, 16'd2, 16'd7, 16'd10};
  logic [CfgDataW-1:0] size_limit_tab[9] = '{16'd8192, 16'd0, 16'hFFFF, 16'd100, 16'd2048,
                                             16'd1, 16'd8192, 16'd5000, 16'd8192};

  priority_message_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  pmq_checker #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending_count),
    .checked_o   (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("priority_message_queue test failed");
    $finish;
  end

  function automatic pmq_in_t build_cmd(input cmd_e op, input int prio, input int len,
                                        input logic [DescW-1:0] desc);
    pmq_in_t item;
    item.command      = op;
    item.priority_req = ReqPrioW'(prio);
    item.length       = ReqLenW'(len);
    item.payload      = desc;
    return item;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic put_cmd(input pmq_in_t item);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic await_quiet();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MAX_MESSAGE_SIZE) cur_size = data[MaxSizeW-1:0];
    reg_writes++;
  endtask

  // mostly legal sends and receives for the current limits, some raw noise
  function automatic pmq_in_t random_cmd(input int send_pct);
    pmq_in_t item;
    int      lim;
    lim = (cur_size < MaxLength) ? cur_size : MaxLength;
    item.payload = $urandom;
    if ($urandom_range(99) < 12) begin
      item.command      = cmd_e'($urandom_range(1));
      item.priority_req = ReqPrioW'($urandom);
      item.length       = ReqLenW'($urandom);
    end else if ($urandom_range(99) < send_pct) begin
      item.command = CMD_SEND;
      case ($urandom_range(3))
        0:       item.priority_req = ReqPrioW'($urandom_range(3));
        1:       item.priority_req = ReqPrioW'($urandom_range(PriorityLevels - 1));
        2:       item.priority_req = $urandom_range(1) ? ReqPrioW'(PriorityLevels - 1) : '0;
        default: item.priority_req = ReqPrioW'($urandom_range(20, 16));
      endcase
      item.length = ($urandom_range(4) == 0) ? ReqLenW'(lim) : ReqLenW'($urandom_range(lim));
    end else begin
      item.command      = CMD_RECV;
      item.priority_req = ReqPrioW'($urandom);
      item.length       = ($urandom_range(3) == 0) ? ReqLenW'(cur_size)
                                                   : ReqLenW'($urandom_range(16'hFFFF, cur_size));
    end
    return item;
  endfunction

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refusals on an empty queue, check order on sends, extreme fields
    put_cmd(build_cmd(CMD_RECV, 0, 8192, '0));
    put_cmd(build_cmd(CMD_RECV, 0, 8191, '0));
    put_cmd(build_cmd(CMD_SEND, 32768, 65535, 32'h1));
    put_cmd(build_cmd(CMD_SEND, 65535, 0, 32'h2));
    put_cmd(build_cmd(CMD_SEND, 32767, 8193, 32'h3));
    put_cmd(build_cmd(CMD_SEND, 0, 65535, 32'h4));
    put_cmd(build_cmd(CMD_SEND, 0, 0, '0));
    put_cmd(build_cmd(CMD_SEND, 32767, 8192, 32'hFFFF_FFFF));
    for (int i = 0; i < 4; i++) put_cmd(build_cmd(CMD_SEND, 7, 100 * (i + 1), 32'hA5A5_0000 + i));
    put_cmd(build_cmd(CMD_RECV, 0, 0, '0));

    // limit dropped under the current count: sends refused until drained
    await_quiet();
    write_reg(CFG_MAX_MESSAGES, 16'd3);
    put_cmd(build_cmd(CMD_SEND, 9, 10, 32'h5));
    put_cmd(build_cmd(CMD_SEND, 40000, 10, 32'h6));
    put_cmd(build_cmd(CMD_SEND, 9, 9000, 32'h7));
    repeat (4) put_cmd(build_cmd(CMD_RECV, 0, 65535, '0));
    put_cmd(build_cmd(CMD_SEND, 7, 50, 32'h8));
    put_cmd(build_cmd(CMD_SEND, 7, 60, 32'h9));
    repeat (4) put_cmd(build_cmd(CMD_RECV, 0, 65535, '0));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct  = 38;
          out_idle_pct = 75;
        end
        1: begin
          in_idle_pct  = 75;
          out_idle_pct = 38;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        await_quiet();
        write_reg(CFG_MAX_MESSAGES, msg_limit_tab[ph * 3 + s]);
        write_reg(CFG_MAX_MESSAGE_SIZE, size_limit_tab[ph * 3 + s]);
        if (s == 0) write_reg((ph == 1) ? CfgIdxSpare1 : CfgIdxSpare0, CfgDataW'($urandom));
        // alternate fill-heavy and drain-heavy stretches
        for (int n = 0; n < 112; n++) put_cmd(random_cmd(((n / 16) % 2 == 0) ? 75 : 30));
      end
    end

    await_quiet();
    repeat (3) @(posedge clk_i);
    $display("ran %0d commands and %0d register writes under three pacing modes",
             sent_count, reg_writes);
    $display("compared %0d results, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("priority_message_queue test passed");
    end else begin
      $display("priority_message_queue test failed");
    end
    $finish;
  end

endmodule

FILE: priority_message_queue.f
design/pmq_pkg.sv
design/pmq_cell.sv
design/priority_message_queue.sv
design/pmq_checker.sv
dv/pmq_checker.sv
dv/testbench.sv
